// ----- rtl/sync_pattern_block_deframer_defines.svh -----
// assertion macros shared by the deframer rtl
`ifndef SYNC_PATTERN_BLOCK_DEFRAMER_DEFINES_SVH
`define SYNC_PATTERN_BLOCK_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define SPBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ----- rtl/spbd_pkg.sv -----
// shared types and constants of the sync pattern block deframer
`default_nettype none

package spbd_pkg;

  // framing constants
  localparam int unsigned PatLen        = 8;
  localparam int unsigned HeaderLen     = 16;
  localparam int unsigned FrameOverhead = 24;
  localparam int unsigned MaxBlockDefault = 32768;

  localparam logic [7:0] StartPat [0:7] = '{
    8'hAA, 8'hD6, 8'h3E, 8'h69, 8'h02, 8'h5A, 8'h7F, 8'h55
  };
  localparam logic [7:0] EndPat [0:7] = '{
    8'h55, 8'h7F, 8'h5A, 8'h02, 8'h69, 8'h3E, 8'hD6, 8'hAA
  };

  // error codes
  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrStart = 3'd1;
  localparam logic [2:0] ErrSize  = 3'd2;
  localparam logic [2:0] ErrSeq   = 3'd3;
  localparam logic [2:0] ErrEnd   = 3'd4;

  // one marked output word
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        in_body;
    logic        block_end;
    logic [2:0]  error_code;
    logic [31:0] block_seq;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/spbd_if.sv -----
// valid/ready stream interfaces for the deframer input and output words
`default_nettype none

interface spbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface spbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        in_body;
  logic        block_end;
  logic [2:0]  error_code;
  logic [31:0] block_seq;

  modport source (output valid, output out_byte, output in_body, output block_end,
                  output error_code, output block_seq, input ready);
  modport sink (input valid, input out_byte, input in_body, input block_end,
                input error_code, input block_seq, output ready);
endinterface

`default_nettype wire

// ----- rtl/sync_pattern_block_deframer.sv -----
// each accepted input word gives its marked output word from the output register in the next cycle
// throughput: one word per cycle while the output side is ready; the framing state updates once per byte
// the output register frees its slot in the same cycle its word is taken
// reset (rst, synchronous, active high) empties the output register and
// returns to header hunting with last good sequence and captures at zero
`default_nettype none

`include "sync_pattern_block_deframer_defines.svh"

module sync_pattern_block_deframer #(
  parameter int unsigned MAX_BLOCK = spbd_pkg::MaxBlockDefault
) (
  input  logic              clk,
  input  logic              rst,
  spbd_in_if.sink           data,
  spbd_out_if.source        result
);
  import spbd_pkg::*;

  logic    take;
  logic    out_valid;
  result_t res;
  result_t res_q;

  // accept whenever the output slot is empty or draining
  assign data.ready = !out_valid || result.ready;
  assign take       = data.valid && data.ready;

  spbd_core #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data.data_byte),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_byte   = res_q.out_byte;
  assign result.in_body    = res_q.in_body;
  assign result.block_end  = res_q.block_end;
  assign result.error_code = res_q.error_code;
  assign result.block_seq  = res_q.block_seq;

  `SPBD_ASSERT_NEXT(a_take_fills, clk, rst, take, out_valid)
  `SPBD_ASSERT_NOW(a_err_no_marks, clk, rst, out_valid && res_q.error_code != ErrNone,
    !res_q.in_body && !res_q.block_end)
  `SPBD_ASSERT_NOW(a_marks_exclusive, clk, rst, out_valid, !(res_q.in_body && res_q.block_end))

endmodule

`default_nettype wire

// ----- rtl/spbd_core.sv -----
// framing state machine: header checks, body marking and trailer check per byte
`default_nettype none

`include "sync_pattern_block_deframer_defines.svh"

module spbd_core #(
  parameter int unsigned MAX_BLOCK = spbd_pkg::MaxBlockDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       data_byte,
  output spbd_pkg::result_t res
);
  import spbd_pkg::*;

  localparam logic PhHeader = 1'b0;
  localparam logic PhBody   = 1'b1;

  localparam logic [32:0] MaxTotal = 33'(MAX_BLOCK);

  logic        phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] block_total, block_total_next;
  logic [31:0] length_capture, length_capture_next;
  logic [31:0] seq_capture, seq_capture_next;
  logic [31:0] last_good_seq, last_good_seq_next;
  logic        trailer_match, trailer_match_next;

  logic        body, done;
  logic [2:0]  err;
  logic [31:0] len_shift, seq_shift;
  logic [32:0] total_calc;
  logic [16:0] total_eff, pos_ext, pos_plus8, trail_off;
  logic        tm_upd;

  // next state and marks for the byte at the input
  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    block_total_next    = block_total;
    length_capture_next = length_capture;
    seq_capture_next    = seq_capture;
    last_good_seq_next  = last_good_seq;
    trailer_match_next  = trailer_match;
    body = 1'b0;
    done = 1'b0;
    err  = ErrNone;

    len_shift  = {length_capture[23:0], data_byte};
    seq_shift  = {seq_capture[23:0], data_byte};
    total_calc = {1'b0, len_shift} + 33'(FrameOverhead);
    total_eff  = (block_total < 16'(FrameOverhead)) ? 17'(FrameOverhead)
                                                    : {1'b0, block_total};
    pos_ext    = {1'b0, byte_position};
    pos_plus8  = pos_ext + 17'(PatLen);
    trail_off  = pos_plus8 - total_eff;
    tm_upd     = trailer_match & (data_byte == EndPat[trail_off[2:0]]);

    if (phase == PhHeader) begin
      if (byte_position < 16'(PatLen)) begin
        // start pattern, resync on a first pattern byte
        if (data_byte == StartPat[byte_position[2:0]]) begin
          byte_position_next = byte_position + 16'd1;
        end else begin
          err                = ErrStart;
          trailer_match_next = 1'b1;
          byte_position_next = (data_byte == StartPat[0]) ? 16'd1 : 16'd0;
        end
      end else if (byte_position < 16'd12) begin
        // big-endian length, size check on its last byte
        length_capture_next = len_shift;
        byte_position_next  = byte_position + 16'd1;
        if (byte_position == 16'd11) begin
          if (total_calc > MaxTotal) begin
            err                = ErrSize;
            byte_position_next = 16'd0;
            trailer_match_next = 1'b1;
          end else begin
            block_total_next = total_calc[15:0];
          end
        end
      end else begin
        // big-endian sequence, must follow the last good one
        seq_capture_next   = seq_shift;
        byte_position_next = byte_position + 16'd1;
        if (byte_position >= 16'(HeaderLen - 1)) begin
          if (seq_shift != last_good_seq + 32'd1) begin
            err                = ErrSeq;
            byte_position_next = 16'd0;
            trailer_match_next = 1'b1;
          end else begin
            last_good_seq_next = seq_shift;
            phase_next         = PhBody;
            trailer_match_next = 1'b1;
          end
        end
      end
    end else begin
      if (pos_plus8 < total_eff) begin
        body               = 1'b1;
        byte_position_next = byte_position + 16'd1;
      end else begin
        // trailer bytes, verdict on the last one
        trailer_match_next = tm_upd;
        if (pos_ext + 17'd1 >= total_eff) begin
          if (tm_upd) begin
            done = 1'b1;
          end else begin
            err = ErrEnd;
          end
          phase_next         = PhHeader;
          byte_position_next = 16'd0;
          trailer_match_next = 1'b1;
        end else begin
          byte_position_next = byte_position + 16'd1;
        end
      end
    end
  end

  // output word for this byte
  always_comb begin
    res.out_byte   = data_byte;
    res.in_body    = body;
    res.block_end  = done;
    res.error_code = err;
    res.block_seq  = seq_capture_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PhHeader;
      byte_position  <= '0;
      block_total    <= '0;
      length_capture <= '0;
      seq_capture    <= '0;
      last_good_seq  <= '0;
      trailer_match  <= 1'b1;
    end else if (take) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      block_total    <= block_total_next;
      length_capture <= length_capture_next;
      seq_capture    <= seq_capture_next;
      last_good_seq  <= last_good_seq_next;
      trailer_match  <= trailer_match_next;
    end
  end

  `SPBD_ASSERT_NOW(a_header_pos, clk, rst, phase == PhHeader, byte_position < 16'(HeaderLen))
  `SPBD_ASSERT_NOW(a_body_pos, clk, rst, phase == PhBody,
    byte_position >= 16'(HeaderLen) && block_total >= 16'(FrameOverhead))
  `SPBD_ASSERT_NEXT(a_err_restart, clk, rst, take && err != ErrNone, phase == PhHeader)

endmodule

`default_nettype wire
